// ===== rtl/core/rrte_pkg.sv =====
// ----------------------------------------------------------------------------
// rrte_pkg
// Shared types and constants of the route table engine.
// ----------------------------------------------------------------------------
`default_nettype none
package rrte_pkg;

    localparam logic [4:0] METRIC_INF = 5'd16;

    localparam logic [2:0] ST_REPLACED = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_DUMP     = 3'd0;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] dest_addr;
        logic [5:0]  prefix_len;
        logic [4:0]  cand;
        logic [31:0] source_ip;
        logic [1:0]  if_num;
        logic        if_ok;
        logic        entry_last;
    } item_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [5:0]  len;
        logic [1:0]  iface;
        logic [31:0] hop;
        logic [3:0]  metric;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/rip_route_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// rip_route_table_engine_unit
// RIP route table with update and poison-reverse dump requests.
// ----------------------------------------------------------------------------
// An update request scans the N routes from the first, and a deletion then
// moves the later routes down; a dump streams every route, waiting while the
// result side stalls. The route memory has one read and one write port and is
// read one entry a cycle by the table sequencer unless the result side stalls.
// A two-entry request queue keeps accepting until full while the sequencer works.
`default_nettype none
module rip_route_table_engine_unit #(
    parameter int TABLE_DEPTH = 32,
    parameter int IF_COUNT    = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic        req_type,
    input  wire logic [31:0] dest_addr,
    input  wire logic [5:0]  prefix_len,
    input  wire logic [4:0]  rx_metric,
    input  wire logic [31:0] source_ip,
    input  wire logic [1:0]  if_num,
    input  wire logic        entry_last,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [2:0]       out_status,
    output logic [31:0]      out_addr,
    output logic [5:0]       out_prefix_len,
    output logic [31:0]      out_nexthop,
    output logic [4:0]       out_metric,
    output logic             out_valid,
    output logic [5:0]       out_count,
    output logic             out_last
);

    logic            q_valid;
    logic            q_pop;
    rrte_pkg::item_t q_item;

    rrte_front #(.IF_COUNT(IF_COUNT)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .dest_addr  (dest_addr),
        .prefix_len (prefix_len),
        .rx_metric  (rx_metric),
        .source_ip  (source_ip),
        .if_num     (if_num),
        .entry_last (entry_last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    rrte_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .out_status     (out_status),
        .out_addr       (out_addr),
        .out_prefix_len (out_prefix_len),
        .out_nexthop    (out_nexthop),
        .out_metric     (out_metric),
        .out_valid      (out_valid),
        .out_count      (out_count),
        .out_last       (out_last)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(out_count) <= TABLE_DEPTH))
        else $error("route count above table depth");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_status <= rrte_pkg::ST_FULL))
        else $error("status code out of range");

    a_update_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_status != rrte_pkg::ST_REPLACED) |-> !out_valid)
        else $error("update result carries an entry");

    a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_valid) |-> (out_count != 6'd0))
        else $error("dumped entry from an empty table");

endmodule
`default_nettype wire

// ===== rtl/core/rrte_front.sv =====
// ----------------------------------------------------------------------------
// rrte_front
// Accepts requests, forms the capped metric and interface check, and holds
// them in a two-entry queue for the table sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module rrte_front #(
    parameter int IF_COUNT = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire logic           req_type,
    input  wire logic [31:0]    dest_addr,
    input  wire logic [5:0]     prefix_len,
    input  wire logic [4:0]     rx_metric,
    input  wire logic [31:0]    source_ip,
    input  wire logic [1:0]     if_num,
    input  wire logic           entry_last,
    output logic                q_valid,
    output rrte_pkg::item_t     q_item,
    input  wire logic           q_pop
);

    rrte_pkg::item_t q_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      cnt_reg;
    rrte_pkg::item_t item;
    logic            push;
    logic            pop;

    always_comb
    begin
        item.req_type   = req_type;
        item.dest_addr  = dest_addr;
        item.prefix_len = prefix_len;
        item.cand       = (rx_metric >= rrte_pkg::METRIC_INF) ? rrte_pkg::METRIC_INF
                                                              : rx_metric + 5'd1;
        item.source_ip  = source_ip;
        item.if_num     = if_num;
        item.if_ok      = (32'(if_num) < IF_COUNT);
        item.entry_last = entry_last;
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = q_reg[rptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rrte_back.sv =====
// ----------------------------------------------------------------------------
// rrte_back
// Table sequencer: searches, replaces, appends and deletes routes in the
// route memory, and streams dumps through the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rrte_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  rrte_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output logic [2:0]          out_status,
    output logic [31:0]         out_addr,
    output logic [5:0]          out_prefix_len,
    output logic [31:0]         out_nexthop,
    output logic [4:0]          out_metric,
    output logic                out_valid,
    output logic [5:0]          out_count,
    output logic                out_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;

    rrte_pkg::entry_t mem [TABLE_DEPTH];
    rrte_pkg::entry_t rdata_reg;
    rrte_pkg::entry_t wdata;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    wr_idx;
    logic             we;

    logic [2:0]       state_reg, state_next;
    rrte_pkg::item_t  cur_reg, cur_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;

    logic             vld_reg, vld_next;
    logic [2:0]       st_reg, st_next;
    logic [31:0]      addr_reg, addr_next;
    logic [5:0]       len_reg, len_next;
    logic [31:0]      hop_reg, hop_next;
    logic [4:0]       met_reg, met_next;
    logic             ev_reg, ev_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             last_reg, last_next;

    logic             hit;
    logic             better;
    logic [CW-1:0]    idx1;
    logic [CW-1:0]    idx2;
    logic             out_free;

    assign idx1     = CW'(idx_reg) + CW'(1);
    assign idx2     = CW'(idx_reg) + CW'(2);
    assign out_free = !vld_reg || rsp_ready;
    assign hit      = (rdata_reg.addr == cur_reg.dest_addr)
                   && (rdata_reg.len == cur_reg.prefix_len);
    assign better   = ((cur_reg.source_ip == rdata_reg.hop)
                       && (cur_reg.cand != {1'b0, rdata_reg.metric}))
                   || (cur_reg.cand < {1'b0, rdata_reg.metric});

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_idx] <= wdata;
        end
        rdata_reg <= mem[rd_idx];
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        vld_next   = vld_reg && !rsp_ready;
        st_next    = st_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        hop_next   = hop_reg;
        met_next   = met_reg;
        ev_next    = ev_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        rd_idx     = idx_reg;
        wr_idx     = idx_reg;
        wdata      = rdata_reg;
        we         = 1'b0;
        q_pop      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !vld_reg)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                idx_next  = '0;
                rd_idx    = '0;
                st_next   = rrte_pkg::ST_IGNORED;
                addr_next = '0;
                len_next  = '0;
                hop_next  = '0;
                met_next  = '0;
                ev_next   = 1'b0;
                cnt_next  = 6'(count_reg);
                last_next = cur_reg.entry_last;
                if (cur_reg.req_type == rrte_pkg::REQ_DUMP)
                begin
                    if (count_reg == '0)
                    begin
                        st_next    = rrte_pkg::ST_DUMP;
                        last_next  = 1'b1;
                        vld_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DUMP;
                    end
                end
                else if (!cur_reg.if_ok)
                begin
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    if (cur_reg.cand != rrte_pkg::METRIC_INF)
                    begin
                        we         = 1'b1;
                        wr_idx     = '0;
                        wdata      = '{cur_reg.dest_addr, cur_reg.prefix_len,
                                       cur_reg.if_num, cur_reg.source_ip,
                                       cur_reg.cand[3:0]};
                        count_next = CW'(1);
                        cnt_next   = 6'd1;
                        st_next    = rrte_pkg::ST_ADDED;
                    end
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (!better)
                    begin
                        vld_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (cur_reg.cand == rrte_pkg::METRIC_INF)
                    begin
                        if (idx1 < count_reg)
                        begin
                            rd_idx     = AW'(idx1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            cnt_next   = 6'(count_reg - CW'(1));
                            st_next    = rrte_pkg::ST_DELETED;
                            vld_next   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        we         = 1'b1;
                        wdata      = '{rdata_reg.addr, rdata_reg.len, cur_reg.if_num,
                                       cur_reg.source_ip, cur_reg.cand[3:0]};
                        st_next    = rrte_pkg::ST_REPLACED;
                        vld_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (idx1 == count_reg)
                begin
                    if (cur_reg.cand == rrte_pkg::METRIC_INF)
                    begin
                        st_next = rrte_pkg::ST_IGNORED;
                    end
                    else if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        st_next = rrte_pkg::ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wr_idx     = AW'(count_reg);
                        wdata      = '{cur_reg.dest_addr, cur_reg.prefix_len,
                                       cur_reg.if_num, cur_reg.source_ip,
                                       cur_reg.cand[3:0]};
                        count_next = count_reg + CW'(1);
                        cnt_next   = 6'(count_reg + CW'(1));
                        st_next    = rrte_pkg::ST_ADDED;
                    end
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = AW'(idx1);
                    rd_idx   = AW'(idx1);
                end
            end
            S_SHIFT:
            begin
                we = 1'b1;
                if (idx2 < count_reg)
                begin
                    idx_next = AW'(idx1);
                    rd_idx   = AW'(idx2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    cnt_next   = 6'(count_reg - CW'(1));
                    st_next    = rrte_pkg::ST_DELETED;
                    vld_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    vld_next  = 1'b1;
                    st_next   = rrte_pkg::ST_DUMP;
                    addr_next = rdata_reg.addr;
                    len_next  = rdata_reg.len;
                    hop_next  = rdata_reg.hop;
                    met_next  = (rdata_reg.iface == cur_reg.if_num) ? rrte_pkg::METRIC_INF
                                                                    : {1'b0, rdata_reg.metric};
                    ev_next   = 1'b1;
                    cnt_next  = 6'(count_reg);
                    last_next = (idx1 == count_reg);
                    if (idx1 == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = AW'(idx1);
                        rd_idx   = AW'(idx1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        st_reg   <= st_next;
        addr_reg <= addr_next;
        len_reg  <= len_next;
        hop_reg  <= hop_next;
        met_reg  <= met_next;
        ev_reg   <= ev_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
    end

    assign rsp_valid      = vld_reg;
    assign out_status     = st_reg;
    assign out_addr       = addr_reg;
    assign out_prefix_len = len_reg;
    assign out_nexthop    = hop_reg;
    assign out_metric     = met_reg;
    assign out_valid      = ev_reg;
    assign out_count      = cnt_reg;
    assign out_last       = last_reg;

endmodule
`default_nettype wire

// ===== test/tb_rip_route_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rip_route_table_engine_unit
// Checks route updates and poison-reverse dumps against a table model.
// ----------------------------------------------------------------------------
// Directed requests cover metric extremes, prefix lengths beyond 32, all
// interfaces, replacement, deletion with shifting, a full table and an empty
// dump. Random request sets then work mostly on a small pool of prefixes
// and next hops. The sender runs in bursts and the response side stalls at
// random, with one long hold-off that fills the request queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rip_route_table_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = 32;
    localparam int NUM_IFS = 4;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [31:0] hop;
        logic [4:0]  metric;
        logic        valid;
        logic [5:0]  count;
        logic        last;
    } rsp_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_type;
    logic [31:0] dest_addr;
    logic [5:0]  prefix_len;
    logic [4:0]  rx_metric;
    logic [31:0] source_ip;
    logic [1:0]  if_num;
    logic        entry_last;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [2:0]  out_status;
    logic [31:0] out_addr;
    logic [5:0]  out_prefix_len;
    logic [31:0] out_nexthop;
    logic [4:0]  out_metric;
    logic        out_valid;
    logic [5:0]  out_count;
    logic        out_last;

    rrte_pkg::entry_t routes [DEPTH];
    int               route_total;
    rsp_t             pending_rsps [$];
    int               mismatches;
    int               burst_left;
    bit               hold_rsp;

    rip_route_table_engine_unit #(.TABLE_DEPTH(DEPTH), .IF_COUNT(NUM_IFS)) u_dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req_type(req_type), .dest_addr(dest_addr), .prefix_len(prefix_len),
        .rx_metric(rx_metric), .source_ip(source_ip), .if_num(if_num),
        .entry_last(entry_last), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .out_status(out_status), .out_addr(out_addr), .out_prefix_len(out_prefix_len),
        .out_nexthop(out_nexthop), .out_metric(out_metric), .out_valid(out_valid),
        .out_count(out_count), .out_last(out_last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [2:0] route_update(logic [31:0] addr, logic [5:0] plen,
                                                logic [4:0] rxm, logic [31:0] src,
                                                logic [1:0] ifc);
        logic [4:0] cand;
        int         pos;
        bit         from_hop;
        cand = (rxm >= rrte_pkg::METRIC_INF) ? rrte_pkg::METRIC_INF : rxm + 5'd1;
        pos = -1;
        if (ifc >= NUM_IFS)
            return rrte_pkg::ST_IGNORED;
        for (int i = 0; i < route_total; i++)
            if (pos < 0 && routes[i].addr == addr && routes[i].len == plen)
                pos = i;
        if (pos >= 0)
        begin
            from_hop = (src == routes[pos].hop) && (cand != {1'b0, routes[pos].metric});
            if (!(from_hop || cand < {1'b0, routes[pos].metric}))
                return rrte_pkg::ST_IGNORED;
            if (cand == rrte_pkg::METRIC_INF)
            begin
                for (int j = pos; j + 1 < route_total; j++)
                    routes[j] = routes[j + 1];
                route_total--;
                return rrte_pkg::ST_DELETED;
            end
            routes[pos].hop = src;
            routes[pos].iface = ifc;
            routes[pos].metric = cand[3:0];
            return rrte_pkg::ST_REPLACED;
        end
        if (cand == rrte_pkg::METRIC_INF)
            return rrte_pkg::ST_IGNORED;
        if (route_total >= DEPTH)
            return rrte_pkg::ST_FULL;
        routes[route_total] = '{addr: addr, len: plen, iface: ifc, hop: src,
                                metric: cand[3:0]};
        route_total++;
        return rrte_pkg::ST_ADDED;
    endfunction

    task automatic predict_request(logic rt, logic [31:0] addr, logic [5:0] plen,
                                   logic [4:0] rxm, logic [31:0] src, logic [1:0] ifc,
                                   logic lst);
        rsp_t r;
        if (rt == rrte_pkg::REQ_UPDATE)
        begin
            r = '0;
            r.status = route_update(addr, plen, rxm, src, ifc);
            r.count = 6'(route_total);
            r.last = lst;
            pending_rsps = {pending_rsps, r};
        end
        else if (route_total == 0)
        begin
            r = '0;
            r.last = 1'b1;
            pending_rsps = {pending_rsps, r};
        end
        else
        begin
            for (int i = 0; i < route_total; i++)
            begin
                r.status = rrte_pkg::ST_DUMP;
                r.addr = routes[i].addr;
                r.plen = routes[i].len;
                r.hop = routes[i].hop;
                r.metric = (routes[i].iface == ifc) ? rrte_pkg::METRIC_INF
                                                    : {1'b0, routes[i].metric};
                r.valid = 1'b1;
                r.count = 6'(route_total);
                r.last = (i + 1 == route_total);
                pending_rsps = {pending_rsps, r};
            end
        end
    endtask

    task automatic send_request(logic rt, logic [31:0] addr, logic [5:0] plen,
                                logic [4:0] rxm, logic [31:0] src, logic [1:0] ifc,
                                logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_type <= rt;
        dest_addr <= addr;
        prefix_len <= plen;
        rx_metric <= rxm;
        source_ip <= src;
        if_num <= ifc;
        entry_last <= lst;
        predict_request(rt, addr, plen, rxm, src, ifc, lst);
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic go_idle();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
                report_mismatch("unexpected response", 32'(out_status), 32'd0);
            else
            begin
                want = pending_rsps.pop_front();
                if (out_status !== want.status)
                    report_mismatch("status", 32'(out_status), 32'(want.status));
                if (out_addr !== want.addr)
                    report_mismatch("addr", out_addr, want.addr);
                if (out_prefix_len !== want.plen)
                    report_mismatch("prefix_len", 32'(out_prefix_len), 32'(want.plen));
                if (out_nexthop !== want.hop)
                    report_mismatch("nexthop", out_nexthop, want.hop);
                if (out_metric !== want.metric)
                    report_mismatch("metric", 32'(out_metric), 32'(want.metric));
                if (out_valid !== want.valid)
                    report_mismatch("valid", 32'(out_valid), 32'(want.valid));
                if (out_count !== want.count)
                    report_mismatch("count", 32'(out_count), 32'(want.count));
                if (out_last !== want.last)
                    report_mismatch("last", 32'(out_last), 32'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        int phase;
        phase = int'($realtime / 20.0);
        if (hold_rsp)
            rsp_ready <= 1'b0;
        else if ((phase / 200) % 3 == 2)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic test_empty_and_extremes();
        send_request(rrte_pkg::REQ_DUMP, 32'hFFFF_FFFF, 6'h3F, 5'h1F, 32'hFFFF_FFFF,
                     2'd0, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'h0000_0000, 6'd0, 5'd0, 32'h0000_0000,
                     2'd0, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'd32, 5'd15, 32'hFFFF_FFFF,
                     2'd3, 1'b1);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'h3F, 5'd14, 32'h1234_5678,
                     2'd1, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'h0A00_0000, 6'd8, 5'h1F, 32'h0101_0101,
                     2'd2, 1'b1);
        send_request(rrte_pkg::REQ_UPDATE, 32'h0A00_0000, 6'd8, 5'd16, 32'h0101_0101,
                     2'd2, 1'b0);
        send_request(rrte_pkg::REQ_DUMP, 32'h0, 6'd0, 5'd0, 32'h0, 2'd3, 1'b0);
    endtask

    task automatic test_replace_and_delete();
        send_request(rrte_pkg::REQ_UPDATE, 32'h0000_0000, 6'd0, 5'd0, 32'h0000_0000,
                     2'd1, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'd32, 5'd3, 32'h0202_0202,
                     2'd2, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'd32, 5'd9, 32'h0202_0202,
                     2'd0, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'd32, 5'd9, 32'h0202_0202,
                     2'd0, 1'b1);
        send_request(rrte_pkg::REQ_UPDATE, 32'h0000_0000, 6'd0, 5'd15, 32'h0000_0000,
                     2'd1, 1'b0);
        send_request(rrte_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 6'd32, 5'd20, 32'h0303_0303,
                     2'd1, 1'b0);
        send_request(rrte_pkg::REQ_DUMP, 32'h0, 6'd0, 5'd0, 32'h0, 2'd0, 1'b0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(rrte_pkg::REQ_UPDATE, 32'hC0A8_0000 + i, 6'd24,
                         5'($urandom_range(0, 14)), $urandom, 2'($urandom_range(0, 3)),
                         1'($urandom));
        send_request(rrte_pkg::REQ_DUMP, 32'h0, 6'd0, 5'd0, 32'h0, 2'd2, 1'b1);
        for (int i = 0; i < DEPTH; i++)
            send_request(rrte_pkg::REQ_UPDATE, 32'hC0A8_0000 + i, 6'd24, 5'd16, 32'h0,
                         2'd0, 1'b0);
    endtask

    task automatic test_queue_backpressure();
        fork
            begin
                hold_rsp = 1'b1;
                repeat (60) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        for (int i = 0; i < 8; i++)
            send_request(rrte_pkg::REQ_UPDATE, 32'h0B00_0000 + i, 6'd16, 5'd2,
                         32'h0505_0505, 2'd1, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [31:0] pool_addr [6];
        logic [31:0] pool_hop [3];
        int          kind;
        foreach (pool_addr[i]) pool_addr[i] = $urandom;
        foreach (pool_hop[i]) pool_hop[i] = $urandom;
        for (int n = 0; n < 60; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_request(rrte_pkg::REQ_DUMP, $urandom, 6'($urandom), 5'($urandom),
                             $urandom, 2'($urandom), 1'($urandom));
            else if (kind == 1)
                send_request(rrte_pkg::REQ_UPDATE, $urandom, 6'($urandom), 5'($urandom),
                             $urandom, 2'($urandom), 1'($urandom));
            else
                send_request(rrte_pkg::REQ_UPDATE, pool_addr[$urandom_range(0, 5)],
                             6'($urandom_range(0, 2) * 8 + 16),
                             5'($urandom_range(0, 17)), pool_hop[$urandom_range(0, 2)],
                             2'($urandom), 1'($urandom));
        end
        send_request(rrte_pkg::REQ_DUMP, 32'h0, 6'd0, 5'd0, 32'h0, 2'd1, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = rrte_pkg::REQ_UPDATE;
        dest_addr = '0;
        prefix_len = '0;
        rx_metric = '0;
        source_ip = '0;
        if_num = '0;
        entry_last = 1'b0;
        rsp_ready = 1'b0;
        hold_rsp = 1'b0;
        mismatches = 0;
        route_total = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_replace_and_delete();
        test_queue_backpressure();
        test_full_table();
        test_random_traffic();
        go_idle();
        while (pending_rsps.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
